// ===== hdl/qet_pkg.sv =====
// Shared types and constants for the quoted, escaped tokenizer.
// No dependencies; imported by qet_parse and quoted_escaped_tokenizer.
package qet_pkg;

    localparam int BYTE_W      = 8;
    localparam int MASK_W      = 64;
    localparam int CFG_INDEX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_MASK_0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_MASK_1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_MASK_2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_MASK_3 = 8'd3;

    // Reset delimiter set: TAB, LF, CR and space
    localparam logic [MASK_W-1:0] DELIM_MASK_0_RESET = 64'h0000_0001_0000_2600;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              token_end;
        logic              string_end;
    } qet_result_t;

endpackage

// ===== hdl/qet_parse.sv =====
// Delimiter set registers, tokenizer state and the per-byte parse logic.
// Depends on qet_pkg.
module qet_parse
    import qet_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]      cfg_data,
    input  logic [BYTE_W-1:0]      cur_byte,
    input  logic                   cur_last,
    input  logic                   step,
    output qet_result_t            result
);

    logic [4*MASK_W-1:0] delim_reg;
    logic                in_token_reg;
    logic                in_quote_reg;
    logic                escape_reg;
    logic                in_token_next;
    logic                in_quote_next;
    logic                escape_next;
    logic                is_delim;
    logic                tend;
    logic                bvalid;
    logic [BYTE_W-1:0]   obyte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= {{(3*MASK_W){1'b0}}, DELIM_MASK_0_RESET};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DELIM_MASK_0: delim_reg[0*MASK_W +: MASK_W] <= cfg_data;
                REG_DELIM_MASK_1: delim_reg[1*MASK_W +: MASK_W] <= cfg_data;
                REG_DELIM_MASK_2: delim_reg[2*MASK_W +: MASK_W] <= cfg_data;
                REG_DELIM_MASK_3: delim_reg[3*MASK_W +: MASK_W] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign is_delim = delim_reg[cur_byte];

    always_comb
    begin
        in_token_next = in_token_reg;
        in_quote_next = in_quote_reg;
        escape_next   = escape_reg;
        tend          = 1'b0;
        bvalid        = 1'b0;
        obyte         = CH_NUL;
        if (in_token_reg && escape_reg)
        begin
            escape_next = 1'b0;
            case (cur_byte)
                CH_N:    begin obyte = CH_LF;    bvalid = 1'b1; end
                CH_T:    begin obyte = CH_TAB;   bvalid = 1'b1; end
                CH_R:    begin obyte = CH_CR;    bvalid = 1'b1; end
                CH_NUL:  begin obyte = CH_NUL;   bvalid = 1'b0; end
                default: begin obyte = cur_byte; bvalid = 1'b1; end
            endcase
        end
        else if (is_delim && !(in_token_reg && in_quote_reg))
        begin
            if (in_token_reg)
            begin
                tend          = 1'b1;
                in_token_next = 1'b0;
                in_quote_next = 1'b0;
            end
        end
        else
        begin
            in_token_next = 1'b1;
            if (!in_token_reg)
            begin
                in_quote_next = 1'b0;
            end
            if (cur_byte == CH_QUOTE)
            begin
                in_quote_next = !in_quote_next;
            end
            else if (cur_byte == CH_BSLASH)
            begin
                escape_next = 1'b1;
            end
            else
            begin
                obyte  = cur_byte;
                bvalid = 1'b1;
            end
        end
        if (cur_last)
        begin
            // The final byte closes any open token and clears all state.
            tend          = tend || in_token_next;
            in_token_next = 1'b0;
            in_quote_next = 1'b0;
            escape_next   = 1'b0;
        end
    end

    assign result.emit       = bvalid || tend || cur_last;
    assign result.out_byte   = bvalid ? obyte : CH_NUL;
    assign result.byte_valid = bvalid;
    assign result.token_end  = tend;
    assign result.string_end = cur_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg <= 1'b0;
            in_quote_reg <= 1'b0;
            escape_reg   <= 1'b0;
        end
        else if (step)
        begin
            in_token_reg <= in_token_next;
            in_quote_reg <= in_quote_next;
            escape_reg   <= escape_next;
        end
    end

endmodule

// ===== hdl/quoted_escaped_tokenizer.sv =====
// Top level of the quoted, escaped string tokenizer.
// Depends on qet_pkg and qet_parse.
//
// Usage:
//   Input channel (item_valid, item_stall, in_byte, is_last) carries one
//   string byte per transaction; is_last marks the final byte of a string.
//   Output channel (result_valid, result_stall, out_byte, byte_valid,
//   token_end, string_end) carries at most one result per input byte.
//   Bytes that are skipped delimiters, quotes, backslashes or escaped zero
//   bytes produce no result unless they are the final byte of the string.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes the four 64-bit delimiter mask registers; cfg_ready is always
//   high and writes to indexes above 3 are ignored. Write only when idle.
// Timing:
//   One byte is accepted every cycle unless item_stall is high. A byte
//   waits in the input register while its result is computed; the result
//   is then registered in the output register and held there until taken.
//   The tokenizer state is updated as the byte leaves the input register.
// Reset:
//   rst_n clears the valid flags of both pipeline registers and the
//   tokenizer state, and restores the delimiter set to space, TAB, LF and CR.
// Stalls:
//   While result_stall holds a result, a byte that produces a result waits
//   in the input register and item_stall rises; silent bytes still drain.
module quoted_escaped_tokenizer
    import qet_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [BYTE_W-1:0]      in_byte,
    input  logic                   is_last,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   byte_valid,
    output logic                   token_end,
    output logic                   string_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]      cfg_data
);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    qet_result_t       res_reg;
    logic              res_valid_reg;
    qet_result_t       step_res;
    logic              out_free;
    logic              s1_advance;
    logic              s1_load;

    assign cfg_ready  = 1'b1;
    assign out_free   = !res_valid_reg || !result_stall;
    assign s1_advance = s1_valid_reg && (!step_res.emit || out_free);
    assign item_stall = s1_valid_reg && !s1_advance;
    assign s1_load    = item_valid && !item_stall;

    qet_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cur_byte  (s1_byte_reg),
        .cur_last  (s1_last_reg),
        .step      (s1_advance),
        .result    (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load || s1_advance)
        begin
            s1_valid_reg <= s1_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s1_advance && step_res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_advance && step_res.emit)
        begin
            res_reg <= step_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_byte     = res_reg.out_byte;
    assign byte_valid   = res_reg.byte_valid;
    assign token_end    = res_reg.token_end;
    assign string_end   = res_reg.string_end;

    // A result always carries something: a byte, a token end or a string end.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (byte_valid || token_end || string_end))
        else $error("empty result delivered");

    // No byte travels without its valid flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !byte_valid) |-> (out_byte == CH_NUL))
        else $error("out_byte nonzero without byte_valid");

    // The input side only stalls while a byte is waiting on a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid && result_stall))
        else $error("input stalled without a stalled result");

    // A held result is not overwritten while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(res_reg)))
        else $error("stalled result changed");

endmodule
